[rtl/core/es_pkg.sv]
package es_pkg;

    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 11;
    localparam int IDX_W   = 12;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        DP_NOP      = 4'd0,
        DP_START    = 4'd1,
        DP_I_ONE    = 4'd2,
        DP_DOUBLE   = 4'd3,
        DP_BIN_INIT = 4'd4,
        DP_BIN_STEP = 4'd5,
        DP_HIT0     = 4'd6,
        DP_HIT_MID  = 4'd7,
        DP_MISS     = 4'd8
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   mem_write;
        logic   out_load;
    } dp_ctrl_t;

    typedef struct packed {
        logic key_eq;
        logic key_gt;
        logic one_lt_n;
        logic dbl_lt_n;
        logic bin_stop;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/core/es_req_if.sv]
interface es_req_if
    import es_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [INDEX_W-1:0]            write_index;
    logic signed [VALUE_WIDTH-1:0] element_value;
    logic signed [VALUE_WIDTH-1:0] search_key;

    modport source (output valid, command, write_index, element_value, search_key,
                    input ready);
    modport sink (input valid, command, write_index, element_value, search_key,
                  output ready);
endinterface

[rtl/core/es_rsp_if.sv]
interface es_rsp_if
    import es_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink (input valid, found, position, output ready);
endinterface

[rtl/core/es_ctrl.sv]
module es_ctrl
    import es_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_command,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHK0  = 6'b000010,
        S_EXP   = 6'b000100,
        S_BINIT = 6'b001000,
        S_BIN   = 6'b010000,
        S_POST  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        ctrl.op        = DP_NOP;
        ctrl.mem_write = 1'b0;
        ctrl.out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_command == CMD_SEARCH)
                    begin
                        ctrl.op    = DP_START;
                        state_next = S_CHK0;
                    end
                    else
                    begin
                        ctrl.mem_write = 1'b1;
                    end
                end
            end
            S_CHK0:
            begin
                if (stat.key_eq)
                begin
                    ctrl.op    = DP_HIT0;
                    state_next = S_POST;
                end
                else
                begin
                    ctrl.op    = DP_I_ONE;
                    state_next = stat.one_lt_n ? S_EXP : S_BINIT;
                end
            end
            S_EXP:
            begin
                // The probed element is not above the key, so the bound doubles.
                if (stat.key_eq || stat.key_gt)
                begin
                    ctrl.op    = DP_DOUBLE;
                    state_next = stat.dbl_lt_n ? S_EXP : S_BINIT;
                end
                else
                begin
                    state_next = S_BINIT;
                end
            end
            S_BINIT:
            begin
                ctrl.op    = DP_BIN_INIT;
                state_next = S_BIN;
            end
            S_BIN:
            begin
                if (stat.key_eq)
                begin
                    ctrl.op    = DP_HIT_MID;
                    state_next = S_POST;
                end
                else if (stat.bin_stop)
                begin
                    ctrl.op    = DP_MISS;
                    state_next = S_POST;
                end
                else
                begin
                    ctrl.op = DP_BIN_STEP;
                end
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/es_datapath.sv]
module es_datapath
    import es_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_WIDTH  = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [COUNT_W-1:0]            cfg_write_data,
    input  logic [INDEX_W-1:0]            write_index,
    input  logic signed [VALUE_WIDTH-1:0] element_value,
    input  logic signed [VALUE_WIDTH-1:0] search_key,
    input  dp_ctrl_t                      ctrl,
    output dp_stat_t                      stat,
    input  logic                          result_ready,
    output logic                          result_valid,
    output logic                          found,
    output logic [POS_W-1:0]              position
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic signed [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;
    logic signed [VALUE_WIDTH-1:0] key_reg;
    logic [COUNT_W-1:0]            count_reg;
    logic [IDX_W-1:0]              n_reg;
    logic [IDX_W-1:0]              i_reg;
    logic [IDX_W-1:0]              lo_reg;
    logic [IDX_W-1:0]              hi_reg;
    logic [IDX_W-1:0]              mid_reg;
    logic                          hit_found_reg;
    logic [POS_W-1:0]              hit_pos_reg;
    logic                          res_valid_reg;
    logic                          res_found_reg;
    logic [POS_W-1:0]              res_pos_reg;

    logic [COUNT_W-1:0] count_eff;
    logic [IDX_W-1:0]   n_calc;
    logic [IDX_W:0]     i_dbl;
    logic [IDX_W-1:0]   lo_init;
    logic [IDX_W-1:0]   hi_init;
    logic [IDX_W:0]     sum_init;
    logic [IDX_W:0]     sum_lt;
    logic [IDX_W:0]     sum_gt;
    logic [IDX_W-1:0]   mid_init;
    logic [IDX_W-1:0]   mid_lt;
    logic [IDX_W-1:0]   mid_gt;
    logic [IDX_W-1:0]   addr;
    logic               write_ok;

    always_comb
    begin
        count_eff = (count_reg == '0) ? COUNT_W'(1) : count_reg;
        if (int'(count_eff) > MAX_ELEMENTS)
        begin
            n_calc = IDX_W'(MAX_ELEMENTS);
        end
        else
        begin
            n_calc = IDX_W'(count_eff);
        end
    end

    assign i_dbl    = {i_reg, 1'b0};
    assign lo_init  = i_reg >> 1;
    assign hi_init  = (i_reg < n_reg - IDX_W'(1)) ? i_reg : n_reg - IDX_W'(1);
    assign sum_init = {1'b0, lo_init} + {1'b0, hi_init};
    assign mid_init = sum_init[IDX_W:1];
    assign sum_lt   = {1'b0, lo_reg} + {1'b0, mid_reg} - (IDX_W + 1)'(1);
    assign mid_lt   = sum_lt[IDX_W:1];
    assign sum_gt   = {1'b0, mid_reg} + {1'b0, hi_reg} + (IDX_W + 1)'(1);
    assign mid_gt   = sum_gt[IDX_W:1];

    always_comb
    begin
        case (ctrl.op)
            DP_I_ONE:    addr = IDX_W'(1);
            DP_DOUBLE:   addr = i_dbl[IDX_W-1:0];
            DP_BIN_INIT: addr = mid_init;
            DP_BIN_STEP: addr = stat.key_gt ? mid_gt : mid_lt;
            default:     addr = '0;
        endcase
    end

    assign write_ok = int'(write_index) < MAX_ELEMENTS;

    always_ff @(posedge clk)
    begin
        if (ctrl.mem_write && write_ok)
        begin
            mem[AW'(write_index)] <= element_value;
        end
        rd_data_reg <= mem[AW'(addr)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(1);
        end
        else if (cfg_write_en)
        begin
            count_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            DP_START:
            begin
                key_reg <= search_key;
                n_reg   <= n_calc;
            end
            DP_I_ONE:
            begin
                i_reg <= IDX_W'(1);
            end
            DP_DOUBLE:
            begin
                i_reg <= i_dbl[IDX_W-1:0];
            end
            DP_BIN_INIT:
            begin
                lo_reg  <= lo_init;
                hi_reg  <= hi_init;
                mid_reg <= mid_init;
            end
            DP_BIN_STEP:
            begin
                if (stat.key_gt)
                begin
                    lo_reg  <= mid_reg + IDX_W'(1);
                    mid_reg <= mid_gt;
                end
                else
                begin
                    hi_reg  <= mid_reg - IDX_W'(1);
                    mid_reg <= mid_lt;
                end
            end
            DP_HIT0:
            begin
                hit_found_reg <= 1'b1;
                hit_pos_reg   <= POS_W'(1);
            end
            DP_HIT_MID:
            begin
                hit_found_reg <= 1'b1;
                hit_pos_reg   <= POS_W'(mid_reg + IDX_W'(1));
            end
            DP_MISS:
            begin
                hit_found_reg <= 1'b0;
                hit_pos_reg   <= '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            res_found_reg <= hit_found_reg;
            res_pos_reg   <= hit_pos_reg;
        end
    end

    assign stat.key_eq   = (key_reg == rd_data_reg);
    assign stat.key_gt   = (key_reg > rd_data_reg);
    assign stat.one_lt_n = (n_reg > IDX_W'(1));
    assign stat.dbl_lt_n = (i_dbl < {1'b0, n_reg});
    assign stat.bin_stop = stat.key_gt ? (mid_reg == hi_reg) : (mid_reg == lo_reg);
    assign stat.out_free = !res_valid_reg || result_ready;

    assign result_valid = res_valid_reg;
    assign found        = res_found_reg;
    assign position     = res_pos_reg;

endmodule

[rtl/core/exponential_search_sorted_array.sv]
// Exponential search over an ascending array of signed values held in an internal memory.
// An item on the request channel either writes one element (command 0) or starts a
// search for a key (command 1). A write gives no result item. A search gives one result
// item on the response channel: found and the 1-based position. The search first
// compares element 0, then doubles a bound through the array and ends with a binary
// search inside the last interval. Each probe is one read of the memory, which has one
// read port. A search that matches element 0 skips the doubling and binary phases.
// The next item is accepted in the cycle after the result is loaded; writes can follow
// one per cycle. One search runs at a time; writes are taken whenever no search is
// running. The count register is written through cfg_write_en and cfg_write_data; the
// user must write it only while idle, which the block itself does not enforce. At reset
// the count is 1 and no result is pending; the array contents are undefined until
// written. The result sits in an output register, so a new item may be accepted
// while the previous result is still stalled; a finished search waits for that
// register to free before it is delivered.
module exponential_search_sorted_array
    import es_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_WIDTH  = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [COUNT_W-1:0] cfg_write_data,
    es_req_if.sink             request,
    es_rsp_if.source           response
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic     req_ready;

    es_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (request.valid),
        .req_command (request.command),
        .req_ready   (req_ready),
        .stat        (stat),
        .ctrl        (ctrl)
    );

    es_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .write_index    (request.write_index),
        .element_value  (request.element_value),
        .search_key     (request.search_key),
        .ctrl           (ctrl),
        .stat           (stat),
        .result_ready   (response.ready),
        .result_valid   (response.valid),
        .found          (response.found),
        .position       (response.position)
    );

    assign request.ready = req_ready;

endmodule
